>>> rtl/smm_pkg.sv
// Shared types and constants for the stepper move sequencer.
package smm_pkg;

    // Item codes
    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_SERVICE = 2'd1,
        MODE_CHUNK   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    localparam int DATA_W         = 32;
    localparam int CHUNK_MAX      = 65536;          // power of two
    localparam int CHUNK_LOG2     = $clog2(CHUNK_MAX);
    localparam int CHUNK_W        = CHUNK_LOG2 + 1;
    localparam int MS_PER_S       = 1000;
    localparam int TIMEOUT_MARGIN = 250;
    localparam int CHUNK_OVERHEAD = 2;
    // count * 1000 + rate - 1 stays below 1001 * 2^32
    localparam int DIVIDEND_W     = DATA_W + 10;
    localparam int STEP_W         = $clog2(DIVIDEND_W + 1);
    localparam int TOTAL_W        = DIVIDEND_W + 1;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic div_start;
        logic commit;
    } smm_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } smm_status_t;

endpackage

>>> rtl/smm_if.sv
// Valid/ready channel interfaces for input items and result items.
interface smm_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic signed [smm_pkg::DATA_W-1:0] move_steps;
    logic [smm_pkg::DATA_W-1:0]        now_ms;

    modport source (output valid, mode, move_steps, now_ms, input ready);
    modport sink   (input valid, mode, move_steps, now_ms, output ready);
endinterface

interface smm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         moving;
    logic                         direction;
    logic                         chunk_load;
    logic [smm_pkg::CHUNK_W-1:0]  chunk_pulses;
    logic                         pulses_on;
    logic                         timed_out;
    logic                         finished;
    logic                         pending;

    modport source (output valid, moving, direction, chunk_load, chunk_pulses, pulses_on,
                    timed_out, finished, pending, input ready);
    modport sink   (input valid, moving, direction, chunk_load, chunk_pulses, pulses_on,
                    timed_out, finished, pending, output ready);
endinterface

>>> rtl/smm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module smm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [smm_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [smm_pkg::DATA_W-1:0]         divisor,
    output logic [smm_pkg::DIVIDEND_W-1:0]     quotient,
    output logic                               done
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [smm_pkg::STEP_W-1:0]         step_reg;
    logic [smm_pkg::DIVIDEND_W-1:0]     quo_reg;
    logic [smm_pkg::DATA_W-1:0]         rem_reg;
    logic [smm_pkg::DATA_W-1:0]         div_reg;

    logic [smm_pkg::DATA_W:0]           rem_shift;
    logic [smm_pkg::DATA_W:0]           rem_diff;
    logic                               bit_ok;
    logic [smm_pkg::DATA_W-1:0]         rem_next;

    // One trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[smm_pkg::DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        bit_ok    = (rem_shift >= {1'b0, div_reg});
        rem_next  = bit_ok ? rem_diff[smm_pkg::DATA_W-1:0] : rem_shift[smm_pkg::DATA_W-1:0];
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + smm_pkg::STEP_W'(1);
            if (step_reg == smm_pkg::STEP_W'(smm_pkg::DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[smm_pkg::DIVIDEND_W-2:0], bit_ok};
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/smm_datapath.sv
// Move state, mailbox, chunk logic, timeout arithmetic and result register.
module smm_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [smm_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic [1:0]                        mode,
    input  logic signed [smm_pkg::DATA_W-1:0] move_steps,
    input  logic [smm_pkg::DATA_W-1:0]        now_ms,
    input  smm_pkg::smm_ctl_t                 ctl,
    output smm_pkg::smm_status_t              st,
    smm_out_if.source                         rsp
);

    localparam int W = smm_pkg::DATA_W;

    // Configuration and move state
    logic [W-1:0]  rate_reg;
    logic [W-1:0]  mailbox_reg;
    logic          active_reg;
    logic          complete_reg;
    logic [W-1:0]  left_reg;
    logic [W-1:0]  start_time_reg;
    logic [W-1:0]  limit_reg;
    logic          dir_reg;
    logic          gen_reg;

    // Latched item
    smm_pkg::mode_t item_mode_reg;
    logic [W-1:0]   item_steps_reg;
    logic [W-1:0]   item_now_reg;

    // Result register
    logic                        out_valid_reg;
    logic                        out_moving_reg;
    logic                        out_dir_reg;
    logic                        out_load_reg;
    logic [smm_pkg::CHUNK_W-1:0] out_chunk_reg;
    logic                        out_gen_reg;
    logic                        out_tout_reg;
    logic                        out_fin_reg;
    logic                        out_pend_reg;

    logic [smm_pkg::DIVIDEND_W-1:0] quotient;
    logic                           div_done;
    logic [smm_pkg::DIVIDEND_W-1:0] dividend;

    logic                        is_service;
    logic                        is_chunk;
    logic                        retire;
    logic                        abort;
    logic                        active_mid;
    logic                        start_move;
    logic                        launch;
    logic                        req_neg;
    logic [W-1:0]                count;
    logic [W-1:0]                elapsed;
    logic                        chunk_event;
    logic                        do_load;
    logic [W-1:0]                load_src;
    logic [smm_pkg::CHUNK_W-1:0] chunk;
    logic [W-1:0]                left_after;
    logic [W:0]                  count_round;
    logic [smm_pkg::CHUNK_W-1:0] chunks;
    logic [smm_pkg::TOTAL_W-1:0] total;
    logic [W-1:0]                limit_sat;

    logic [W-1:0]  mailbox_next;
    logic          active_next;
    logic          complete_next;
    logic [W-1:0]  left_next;
    logic [W-1:0]  start_time_next;
    logic [W-1:0]  limit_next;
    logic          dir_next;
    logic          gen_next;

    // Item decode against current state
    always_comb
    begin
        is_service  = (item_mode_reg == smm_pkg::MODE_SERVICE);
        is_chunk    = (item_mode_reg == smm_pkg::MODE_CHUNK);
        elapsed     = item_now_reg - start_time_reg;
        retire      = is_service && active_reg && complete_reg;
        abort       = is_service && active_reg && !complete_reg && (elapsed >= limit_reg);
        active_mid  = active_reg && !retire && !abort;
        start_move  = is_service && (mailbox_reg != '0) && !active_mid;
        launch      = start_move && (rate_reg != '0);
        req_neg     = mailbox_reg[W-1];
        count       = req_neg ? (W'(0) - mailbox_reg) : mailbox_reg;
        chunk_event = is_chunk && active_reg && (left_reg != '0);
        do_load     = launch || chunk_event;
        load_src    = launch ? count : left_reg;
        if (load_src > W'(smm_pkg::CHUNK_MAX))
            chunk = smm_pkg::CHUNK_W'(smm_pkg::CHUNK_MAX);
        else
            chunk = load_src[smm_pkg::CHUNK_W-1:0];
        left_after  = load_src - W'(chunk);
        dividend    = smm_pkg::DIVIDEND_W'(count) * smm_pkg::DIVIDEND_W'(smm_pkg::MS_PER_S)
                    + smm_pkg::DIVIDEND_W'(rate_reg) - smm_pkg::DIVIDEND_W'(1);
    end

    // Timeout limit from the divider result
    always_comb
    begin
        count_round = {1'b0, count} + (W + 1)'(smm_pkg::CHUNK_MAX - 1);
        chunks      = count_round[W:smm_pkg::CHUNK_LOG2];
        total       = {1'b0, quotient}
                    + smm_pkg::TOTAL_W'(smm_pkg::TIMEOUT_MARGIN)
                    + smm_pkg::TOTAL_W'(chunks) * smm_pkg::TOTAL_W'(smm_pkg::CHUNK_OVERHEAD);
        if (total[smm_pkg::TOTAL_W-1:W] != '0)
            limit_sat = '1;
        else
            limit_sat = total[W-1:0];
    end

    // Next state for commit
    always_comb
    begin
        mailbox_next    = mailbox_reg;
        active_next     = active_reg;
        complete_next   = complete_reg;
        left_next       = left_reg;
        start_time_next = start_time_reg;
        limit_next      = limit_reg;
        dir_next        = dir_reg;
        gen_next        = gen_reg;

        case (item_mode_reg)
            smm_pkg::MODE_WRITE:
            begin
                mailbox_next = item_steps_reg;
            end
            smm_pkg::MODE_SERVICE:
            begin
                if (retire || abort)
                begin
                    active_next   = 1'b0;
                    complete_next = 1'b0;
                    left_next     = '0;
                end
                if (abort)
                    gen_next = 1'b0;
                if (start_move)
                begin
                    mailbox_next = '0;
                    dir_next     = !req_neg;
                end
                if (launch)
                begin
                    limit_next      = limit_sat;
                    left_next       = left_after;
                    complete_next   = 1'b0;
                    active_next     = 1'b1;
                    start_time_next = item_now_reg;
                    gen_next        = 1'b1;
                end
            end
            smm_pkg::MODE_CHUNK:
            begin
                if (active_reg)
                begin
                    if (left_reg != '0)
                    begin
                        left_next = left_after;
                        gen_next  = 1'b1;
                    end
                    else
                    begin
                        gen_next      = 1'b0;
                        complete_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration and move state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= '0;
            mailbox_reg    <= '0;
            active_reg     <= 1'b0;
            complete_reg   <= 1'b0;
            left_reg       <= '0;
            start_time_reg <= '0;
            limit_reg      <= '0;
            dir_reg        <= 1'b0;
            gen_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                rate_reg <= cfg_wdata;
            if (ctl.commit)
            begin
                mailbox_reg    <= mailbox_next;
                active_reg     <= active_next;
                complete_reg   <= complete_next;
                left_reg       <= left_next;
                start_time_reg <= start_time_next;
                limit_reg      <= limit_next;
                dir_reg        <= dir_next;
                gen_reg        <= gen_next;
            end
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            item_mode_reg  <= smm_pkg::mode_t'(mode);
            item_steps_reg <= move_steps;
            item_now_reg   <= now_ms;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.commit)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_moving_reg <= active_next;
            out_dir_reg    <= dir_next;
            out_load_reg   <= do_load;
            out_chunk_reg  <= do_load ? chunk : '0;
            out_gen_reg    <= gen_next;
            out_tout_reg   <= abort;
            out_fin_reg    <= retire;
            out_pend_reg   <= (mailbox_next != '0);
        end
    end

    smm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (rate_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Status to controller
    assign st.need_div = launch;
    assign st.div_done = div_done;
    assign st.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.moving       = out_moving_reg;
    assign rsp.direction    = out_dir_reg;
    assign rsp.chunk_load   = out_load_reg;
    assign rsp.chunk_pulses = out_chunk_reg;
    assign rsp.pulses_on    = out_gen_reg;
    assign rsp.timed_out    = out_tout_reg;
    assign rsp.finished     = out_fin_reg;
    assign rsp.pending      = out_pend_reg;

endmodule

>>> rtl/smm_ctrl.sv
// Item sequencing state machine: take, evaluate, divide, commit.
module smm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smm_pkg::smm_status_t st,
    output smm_pkg::smm_ctl_t    ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands
    assign in_ready      = (state_reg == S_IDLE);
    assign ctl.take      = in_valid && in_ready;
    assign ctl.div_start = (state_reg == S_EVAL) && st.need_div;
    assign ctl.commit    = (state_reg == S_COMMIT) && st.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = st.need_div ? S_DIV : S_COMMIT;
            end
            S_DIV:
            begin
                if (st.div_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/stepper_move_sequencer.sv
// Top level of the stepper move sequencer.
// Every item gives exactly one result. An item is evaluated in the cycle after it is
// taken; one that needs no division enters the commit state in the cycle after that.
// A service item that starts a move at a nonzero pulse rate first runs the 42-bit
// restoring divider for its timeout, one quotient bit per cycle, before its commit.
// A result waits in the output register while the next item is taken; commit stalls
// only while that register is full and not taken. The user must write the pulse rate
// register (cfg_write/cfg_wdata) only while no item is in work; the block does not check.
module stepper_move_sequencer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [smm_pkg::DATA_W-1:0] cfg_wdata,
    smm_in_if.sink                     cmd,
    smm_out_if.source                  rsp
);

    smm_pkg::smm_ctl_t    ctl;
    smm_pkg::smm_status_t st;

    smm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .st       (st),
        .ctl      (ctl)
    );

    smm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_wdata  (cfg_wdata),
        .mode       (cmd.mode),
        .move_steps (cmd.move_steps),
        .now_ms     (cmd.now_ms),
        .ctl        (ctl),
        .st         (st),
        .rsp        (rsp)
    );

endmodule

>>> rtl/smm_checker.sv
// Port-level checks for the stepper move sequencer, bound to the top level.
module smm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_ready,
    input  logic                        rsp_valid,
    input  logic                        moving,
    input  logic                        chunk_load,
    input  logic [smm_pkg::CHUNK_W-1:0] chunk_pulses,
    input  logic                        pulses_on,
    input  logic                        timed_out,
    input  logic                        finished
);

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while another is in work");

    // Chunk size only with a load, and a loaded chunk is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (chunk_load == (chunk_pulses != '0)))
        else $error("chunk size does not match chunk load");

    // A loaded chunk starts the pulse generator
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && chunk_load |-> pulses_on)
        else $error("chunk loaded with generator off");

    // Generator runs only during a move
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pulses_on |-> moving)
        else $error("generator on without an active move");

    // A move ends one way only
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(timed_out && finished))
        else $error("move both timed out and retired");

endmodule

bind stepper_move_sequencer smm_checker u_smm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .moving       (rsp.moving),
    .chunk_load   (rsp.chunk_load),
    .chunk_pulses (rsp.chunk_pulses),
    .pulses_on    (rsp.pulses_on),
    .timed_out    (rsp.timed_out),
    .finished     (rsp.finished)
);
